// File: hw/rtl/lsa_pkg.sv
// Shared constants, command codes and control types of the Lorentzian spectrum accumulator.
package lsa_pkg;

    localparam int MAX_BINS_DEF = 1024;

    localparam int CMD_W   = 2;
    localparam int HEIGHT_W = 16;
    localparam int FREQ_W  = 20;
    localparam int WIDTH_W = 16;
    localparam int BIDX_W  = 10;
    localparam int STEP_W  = 16;
    localparam int NUSE_W  = 11;
    localparam int VALUE_W = 32;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 20;

    localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd0;
    localparam logic [CMD_W-1:0] CMD_ADD   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_READ  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_START = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_NUSE  = 2'd2;

    localparam logic [FREQ_W-1:0] START_RST = 20'd0;
    localparam logic [STEP_W-1:0] STEP_RST  = 16'd256;
    localparam logic [NUSE_W-1:0] NUSE_RST  = 11'd1024;

    localparam int INV_PI_W = 15;
    localparam logic [INV_PI_W-1:0] INV_PI_Q16 = 15'd20861;

    localparam int ACC_FREQ_W = 33;
    localparam int AD_W  = 31;
    localparam int HW_W  = HEIGHT_W + WIDTH_W;
    localparam int NUM_W = HW_W + INV_PI_W;
    localparam int SQ_W  = 2 * AD_W;
    localparam int DEN_W = SQ_W + 1;
    localparam int REM_W = DEN_W + 1;
    localparam int DCNT_W = $clog2(NUM_W);

    typedef struct packed {
        logic load;
        logic sweep;
        logic calc_ad;
        logic mul;
        logic den;
        logic div_init;
        logic div_step;
        logic add_wr;
        logic set_out;
    } t_ctl;

    typedef struct packed {
        logic last_clr;
        logic last_add;
        logic none_in_use;
        logic div_skip;
        logic div_last;
    } t_sts;

endpackage

// File: hw/rtl/lsa_datapath.sv
// Datapath: configuration registers, spectrum memory, Lorentzian term arithmetic and divider.
module lsa_datapath #(
    parameter int MAX_BINS = lsa_pkg::MAX_BINS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [lsa_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [lsa_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  logic [lsa_pkg::CMD_W-1:0]       i_cmd,
    input  logic [lsa_pkg::HEIGHT_W-1:0]    i_peak_height,
    input  logic [lsa_pkg::FREQ_W-1:0]      i_peak_center,
    input  logic [lsa_pkg::WIDTH_W-1:0]     i_half_width,
    input  logic [lsa_pkg::BIDX_W-1:0]      i_bin_index,
    input  lsa_pkg::t_ctl                   i_ctl,
    output lsa_pkg::t_sts                   o_sts,
    output logic [lsa_pkg::VALUE_W-1:0]     o_bin_value,
    output logic                            o_is_read_reply
);

    localparam int IW = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1;
    localparam int CW = $clog2(MAX_BINS + 1);
    localparam int NW = (CW > lsa_pkg::NUSE_W) ? CW : lsa_pkg::NUSE_W;
    localparam logic [NW-1:0] NMAX = NW'(MAX_BINS);
    localparam logic [IW-1:0] LAST_IDX = IW'(MAX_BINS - 1);
    localparam int AF = lsa_pkg::ACC_FREQ_W;
    localparam logic [AF-1:0] AD_CLAMP = AF'({lsa_pkg::AD_W{1'b1}});

    logic [lsa_pkg::FREQ_W-1:0]  r_start;
    logic [lsa_pkg::STEP_W-1:0]  r_step;
    logic [lsa_pkg::NUSE_W-1:0]  r_nuse;

    logic [lsa_pkg::CMD_W-1:0]    r_cmd;
    logic [lsa_pkg::FREQ_W-1:0]   r_center;
    logic [lsa_pkg::BIDX_W-1:0]   r_bidx;
    logic [lsa_pkg::HW_W-1:0]     r_hw;
    logic [2*lsa_pkg::WIDTH_W-1:0] r_wsq;

    logic [IW-1:0]                r_idx;
    logic [AF-1:0]                r_freq;
    logic [lsa_pkg::AD_W-1:0]     r_ad;
    logic [lsa_pkg::SQ_W-1:0]     r_sq;
    logic [lsa_pkg::NUM_W-1:0]    r_num;
    logic [lsa_pkg::DEN_W-1:0]    r_den;
    logic [lsa_pkg::REM_W-1:0]    r_rem;
    logic [lsa_pkg::NUM_W-1:0]    r_nsh;
    logic [lsa_pkg::NUM_W-1:0]    r_q;
    logic [lsa_pkg::DCNT_W-1:0]   r_dcnt;

    logic [lsa_pkg::VALUE_W-1:0]  r_mem [MAX_BINS];
    logic [lsa_pkg::VALUE_W-1:0]  r_rdata;
    logic [lsa_pkg::VALUE_W-1:0]  r_bin_value;
    logic                         r_is_read;

    logic [NW-1:0]                w_count;
    logic [NW-1:0]                w_nuse_ext;
    logic [NW-1:0]                w_idx_ext;
    logic [NW-1:0]                w_bidx_ext;
    logic                         w_in_range;
    logic [IW-1:0]                w_raddr;
    logic [AF-1:0]                w_center_ext;
    logic [AF-1:0]                w_diff;
    logic [lsa_pkg::AD_W-1:0]     w_ad;
    logic [lsa_pkg::REM_W-1:0]    w_trial;
    logic                         w_fits;
    logic [lsa_pkg::NUM_W:0]      w_sum;
    logic [lsa_pkg::VALUE_W-1:0]  w_sat;
    logic                         w_we;
    logic [lsa_pkg::VALUE_W-1:0]  w_wdata;

    assign w_nuse_ext = NW'(r_nuse);
    assign w_count    = (w_nuse_ext > NMAX) ? NMAX : w_nuse_ext;
    assign w_idx_ext  = NW'(r_idx);
    assign w_bidx_ext = NW'(r_bidx);
    assign w_in_range = w_bidx_ext < w_count;
    assign w_raddr    = (r_cmd == lsa_pkg::CMD_READ) ? w_bidx_ext[IW-1:0] : r_idx;

    assign w_center_ext = AF'(r_center);
    assign w_diff = (r_freq >= w_center_ext) ? (r_freq - w_center_ext)
                                             : (w_center_ext - r_freq);
    assign w_ad = (w_diff > AD_CLAMP) ? AD_CLAMP[lsa_pkg::AD_W-1:0]
                                      : w_diff[lsa_pkg::AD_W-1:0];

    assign w_trial = {r_rem[lsa_pkg::REM_W-2:0], r_nsh[lsa_pkg::NUM_W-1]};
    assign w_fits  = w_trial >= lsa_pkg::REM_W'(r_den);

    assign w_sum = (lsa_pkg::NUM_W+1)'(r_rdata) + (lsa_pkg::NUM_W+1)'(r_q);
    assign w_sat = (w_sum[lsa_pkg::NUM_W:lsa_pkg::VALUE_W] != '0)
                   ? {lsa_pkg::VALUE_W{1'b1}} : w_sum[lsa_pkg::VALUE_W-1:0];

    assign w_we    = i_ctl.sweep | i_ctl.add_wr;
    assign w_wdata = i_ctl.sweep ? '0 : w_sat;

    assign o_sts.last_clr    = r_idx == LAST_IDX;
    assign o_sts.last_add    = (w_idx_ext + NW'(1)) >= w_count;
    assign o_sts.none_in_use = w_count == '0;
    assign o_sts.div_skip    = (r_den == '0) || (r_den > lsa_pkg::DEN_W'(r_num));
    assign o_sts.div_last    = r_dcnt == '0;

    assign o_bin_value     = r_bin_value;
    assign o_is_read_reply = r_is_read;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start <= lsa_pkg::START_RST;
            r_step  <= lsa_pkg::STEP_RST;
            r_nuse  <= lsa_pkg::NUSE_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                lsa_pkg::CFG_START: r_start <= i_cfg_data;
                lsa_pkg::CFG_STEP:  r_step  <= i_cfg_data[lsa_pkg::STEP_W-1:0];
                lsa_pkg::CFG_NUSE:  r_nuse  <= i_cfg_data[lsa_pkg::NUSE_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= '0;
        end else if (i_ctl.load) begin
            r_idx <= '0;
        end else if (w_we) begin
            r_idx <= r_idx + IW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_cmd    <= i_cmd;
            r_center <= i_peak_center;
            r_bidx   <= i_bin_index;
            r_hw     <= lsa_pkg::HW_W'(i_peak_height) * lsa_pkg::HW_W'(i_half_width);
            r_wsq    <= (2*lsa_pkg::WIDTH_W)'(i_half_width)
                        * (2*lsa_pkg::WIDTH_W)'(i_half_width);
            r_freq   <= AF'(r_start);
        end else if (i_ctl.add_wr) begin
            r_freq   <= r_freq + AF'(r_step);
        end
        if (i_ctl.calc_ad) begin
            r_ad <= w_ad;
        end
        if (i_ctl.mul) begin
            r_sq  <= lsa_pkg::SQ_W'(r_ad) * lsa_pkg::SQ_W'(r_ad);
            r_num <= lsa_pkg::NUM_W'(r_hw) * lsa_pkg::NUM_W'(lsa_pkg::INV_PI_Q16);
        end
        if (i_ctl.den) begin
            r_den <= lsa_pkg::DEN_W'(r_sq) + lsa_pkg::DEN_W'(r_wsq);
        end
        if (i_ctl.div_init) begin
            r_rem  <= '0;
            r_q    <= '0;
            r_nsh  <= r_num;
            r_dcnt <= lsa_pkg::DCNT_W'(lsa_pkg::NUM_W - 1);
        end else if (i_ctl.div_step) begin
            r_rem  <= w_fits ? (w_trial - lsa_pkg::REM_W'(r_den)) : w_trial;
            r_q    <= {r_q[lsa_pkg::NUM_W-2:0], w_fits};
            r_nsh  <= {r_nsh[lsa_pkg::NUM_W-2:0], 1'b0};
            r_dcnt <= r_dcnt - lsa_pkg::DCNT_W'(1);
        end
        if (i_ctl.set_out) begin
            r_is_read   <= r_cmd == lsa_pkg::CMD_READ;
            r_bin_value <= ((r_cmd == lsa_pkg::CMD_READ) && w_in_range) ? r_rdata : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[r_idx] <= w_wdata;
        end
        r_rdata <= r_mem[w_raddr];
    end

endmodule

// File: hw/rtl/lsa_ctrl.sv
// Controller: sequences the clear sweep, per-bin add steps and bin reads.
module lsa_ctrl (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       start,
    input  logic [lsa_pkg::CMD_W-1:0]  i_cmd,
    input  lsa_pkg::t_sts              i_sts,
    output lsa_pkg::t_ctl              o_ctl,
    output logic                       busy,
    output logic                       o_valid
);

    localparam logic [3:0] S_BOOT    = 4'd0;
    localparam logic [3:0] S_IDLE    = 4'd1;
    localparam logic [3:0] S_CLR     = 4'd2;
    localparam logic [3:0] S_ADD_RD  = 4'd3;
    localparam logic [3:0] S_ADD_MUL = 4'd4;
    localparam logic [3:0] S_ADD_DEN = 4'd5;
    localparam logic [3:0] S_ADD_CHK = 4'd6;
    localparam logic [3:0] S_ADD_DIV = 4'd7;
    localparam logic [3:0] S_ADD_WR  = 4'd8;
    localparam logic [3:0] S_RD_MEM  = 4'd9;
    localparam logic [3:0] S_FIN     = 4'd10;
    localparam logic [3:0] S_OUT     = 4'd11;

    logic [3:0] r_state;
    logic [3:0] n_state;

    assign busy    = r_state != S_IDLE;
    assign o_valid = r_state == S_OUT;

    always_comb begin
        n_state = r_state;
        o_ctl   = '0;
        case (r_state)
            S_BOOT: begin
                o_ctl.sweep = 1'b1;
                if (i_sts.last_clr) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (start) begin
                    o_ctl.load = 1'b1;
                    case (i_cmd)
                        lsa_pkg::CMD_CLEAR: n_state = S_CLR;
                        lsa_pkg::CMD_ADD:
                            n_state = i_sts.none_in_use ? S_FIN : S_ADD_RD;
                        lsa_pkg::CMD_READ:  n_state = S_RD_MEM;
                        default:            n_state = S_FIN;
                    endcase
                end
            end
            S_CLR: begin
                o_ctl.sweep = 1'b1;
                if (i_sts.last_clr) n_state = S_FIN;
            end
            S_ADD_RD: begin
                o_ctl.calc_ad = 1'b1;
                n_state = S_ADD_MUL;
            end
            S_ADD_MUL: begin
                o_ctl.mul = 1'b1;
                n_state = S_ADD_DEN;
            end
            S_ADD_DEN: begin
                o_ctl.den = 1'b1;
                n_state = S_ADD_CHK;
            end
            S_ADD_CHK: begin
                o_ctl.div_init = 1'b1;
                n_state = i_sts.div_skip ? S_ADD_WR : S_ADD_DIV;
            end
            S_ADD_DIV: begin
                o_ctl.div_step = 1'b1;
                if (i_sts.div_last) n_state = S_ADD_WR;
            end
            S_ADD_WR: begin
                o_ctl.add_wr = 1'b1;
                n_state = i_sts.last_add ? S_FIN : S_ADD_RD;
            end
            S_RD_MEM: n_state = S_FIN;
            S_FIN: begin
                o_ctl.set_out = 1'b1;
                n_state = S_OUT;
            end
            S_OUT:   n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_BOOT;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// File: hw/rtl/lorentzian_spectrum_accumulator.sv
// Top level of the Lorentzian spectrum accumulator.
// A transaction is taken when start is high and busy is low; its single result
// appears for one cycle on o_valid and cannot be held off. After reset the block
// clears its MAX_BINS-entry memory, one entry a cycle, and stays busy until the
// sweep ends. For each bin in use, add steps through S_ADD_RD, S_ADD_MUL,
// S_ADD_DEN, S_ADD_CHK and S_ADD_WR, and runs the one-bit-per-cycle divider over
// the 47-bit numerator in S_ADD_DIV before the write unless the term is zero.
module lorentzian_spectrum_accumulator #(
    parameter int MAX_BINS = lsa_pkg::MAX_BINS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [lsa_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [lsa_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                            start,
    output logic                            busy,
    input  logic [lsa_pkg::CMD_W-1:0]       i_cmd,
    input  logic [lsa_pkg::HEIGHT_W-1:0]    i_peak_height,
    input  logic [lsa_pkg::FREQ_W-1:0]      i_peak_center,
    input  logic [lsa_pkg::WIDTH_W-1:0]     i_half_width,
    input  logic [lsa_pkg::BIDX_W-1:0]      i_bin_index,
    output logic                            o_valid,
    output logic [lsa_pkg::VALUE_W-1:0]     o_bin_value,
    output logic                            o_is_read_reply
);

    lsa_pkg::t_ctl w_ctl;
    lsa_pkg::t_sts w_sts;

    lsa_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_cmd   (i_cmd),
        .i_sts   (w_sts),
        .o_ctl   (w_ctl),
        .busy    (busy),
        .o_valid (o_valid)
    );

    lsa_datapath #(.MAX_BINS(MAX_BINS)) u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data),
        .i_cmd           (i_cmd),
        .i_peak_height   (i_peak_height),
        .i_peak_center   (i_peak_center),
        .i_half_width    (i_half_width),
        .i_bin_index     (i_bin_index),
        .i_ctl           (w_ctl),
        .o_sts           (w_sts),
        .o_bin_value     (o_bin_value),
        .o_is_read_reply (o_is_read_reply)
    );

endmodule

// File: hw/rtl/lsa_checker.sv
// Port-level checks of the accumulator and their binding to the top level.
module lsa_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        start,
    input logic                        busy,
    input logic                        o_valid,
    input logic [lsa_pkg::VALUE_W-1:0] o_bin_value,
    input logic                        o_is_read_reply
);

    a_valid_while_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> busy) else $error("result outside a transaction");

    a_single_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid) else $error("result strobe longer than one cycle");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> (busy && !o_valid)) else $error("no work after accept");

    a_zero_non_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_is_read_reply) |-> (o_bin_value == '0))
        else $error("nonzero value on a non-read result");

endmodule

bind lorentzian_spectrum_accumulator lsa_checker u_lsa_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .start           (start),
    .busy            (busy),
    .o_valid         (o_valid),
    .o_bin_value     (o_bin_value),
    .o_is_read_reply (o_is_read_reply)
);
